// ===== sv/lmfb_pkg.sv =====
// Shared types and constants of the LED matrix frame builder.
package lmfb_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_EMIT  = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SNAKE  = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    // Control states of the top level
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH
    } state_t;

    // Byte position inside one RGB pixel
    typedef enum logic [1:0] {
        PHASE_RED   = 2'd0,
        PHASE_GREEN = 2'd1,
        PHASE_BLUE  = 2'd2,
        PHASE_BAD   = 2'd3
    } phase_t;

    localparam int DIM_W   = 7;   // width and height register width
    localparam int COORD_W = 6;   // col and row width
    localparam int PCW     = 13;  // pixel count and strip position, up to 64*64
    localparam int CW      = 14;  // frame cursor
    localparam int SUM_W   = 16;

    localparam logic [DIM_W-1:0] DIM_LIMIT   = 7'd64;
    localparam logic [7:0]       HEADER_BYTE = 8'hAA;
    localparam logic             KIND_PIXEL  = 1'b0;
    localparam logic             KIND_FRAME  = 1'b1;

    // Matrix geometry for the current item
    typedef struct packed {
        logic [PCW-1:0] pos;     // strip position of (col,row)
        logic           pos_ok;  // coordinates fall inside the matrix
        logic [CW-1:0]  nbytes;  // pixel bytes in one frame
    } geom_t;

endpackage

// ===== sv/lmfb_store.sv =====
// Pixel store: one write port, one read port with registered read data.
module lmfb_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [23:0]   rd_data
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry; hold the data while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lmfb_geom.sv =====
// Matrix geometry: pixel count, frame length and strip position of a pixel.
module lmfb_geom #(
    parameter int MAX_PIXELS = 4096
) (
    input  logic [lmfb_pkg::DIM_W-1:0]   width,
    input  logic [lmfb_pkg::DIM_W-1:0]   height,
    input  logic                         snake_mode,
    input  logic [lmfb_pkg::COORD_W-1:0] col,
    input  logic [lmfb_pkg::COORD_W-1:0] row,
    output lmfb_pkg::geom_t              geom
);

    import lmfb_pkg::*;

    localparam int unsigned CAP = MAX_PIXELS;

    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [CW-1:0]    prod;
    logic [PCW-1:0]   pcount;
    logic [PCW-1:0]   line_base;
    logic [DIM_W-1:0] col_eff;
    logic [PCW-1:0]   pos;

    // Clamp the dimensions and cap the pixel count
    always_comb
    begin
        eff_w  = (width > DIM_LIMIT) ? DIM_LIMIT : width;
        eff_h  = (height > DIM_LIMIT) ? DIM_LIMIT : height;
        prod   = CW'(eff_w) * CW'(eff_h);
        pcount = (32'(prod) > CAP) ? PCW'(CAP) : PCW'(prod);
    end

    // Map (col,row) to strip order; odd rows run backward in snake mode
    always_comb
    begin
        line_base = PCW'(eff_w) * PCW'(row);
        if (snake_mode && row[0])
        begin
            col_eff = DIM_W'(eff_w - 7'd1 - {1'b0, col});
        end
        else
        begin
            col_eff = {1'b0, col};
        end
        pos = line_base + PCW'(col_eff);
    end

    // Pack the results
    always_comb
    begin
        geom.pos    = pos;
        geom.pos_ok = ({1'b0, col} < eff_w) && ({1'b0, row} < eff_h) && (pos < pcount);
        geom.nbytes = (CW'(pcount) << 1) + CW'(pcount);
    end

endmodule

// ===== sv/led_matrix_frame_builder.sv =====
// Top level of the LED matrix frame builder: command decode, frame sequencer, output item.
//
// Holds an RGB pixel store of MAX_PIXELS entries in strip order (plain or serpentine)
// and serves four commands on the input stream: write a pixel, read a pixel, clear the
// store and emit the next frame byte (0xAA header, R,G,B per pixel, then a 16-bit sum
// high byte first, tlast on the low byte). A pixel write is stored as it is accepted.
// A read or a frame byte first issues the store read, then in ST_FETCH takes the
// registered read data into the output item register once it is free. A clear, and
// the sweep after reset, write one entry per cycle over all MAX_PIXELS entries, during
// which no item is accepted; configuration writes are taken at any time. The output
// register lets a new command be accepted while the previous result waits for m_tready.
module led_matrix_frame_builder #(
    parameter int MAX_PIXELS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // col[5:0], row[11:6], red[19:12], green[27:20],
                                   // blue[35:28], zero[39:36]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16],
                                   // frame_byte[31:24]
    output logic [1:0]  m_tuser,   // kind[0], coord_error[1]
    output logic        m_tlast    // frame_end
);

    import lmfb_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_PIXELS - 1);

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             snake_reg;

    // control
    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic             clr_active;
    logic             load_out;
    logic             s_accept;
    func_t            func;

    // frame sequencer
    logic [CW-1:0]    cursor_reg, cursor_next;
    logic [PCW-1:0]   pix_idx_reg, pix_idx_next;
    phase_t           phase_reg, phase_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    // command context held across the store read
    logic             is_emit_reg;
    logic             pos_ok_reg;

    // output item
    logic             out_valid_reg;
    logic [7:0]       red_out_reg, green_out_reg, blue_out_reg, frame_byte_reg;
    logic             kind_reg, frame_end_reg, coord_error_reg;
    logic [7:0]       red_out_next, green_out_next, blue_out_next, frame_byte_next;
    logic             kind_next, frame_end_next, coord_error_next;

    // store ports
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [23:0]      wr_data, rd_data;
    logic [7:0]       pix_byte;

    geom_t            geom;

    lmfb_geom #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_geom (
        .width      (width_reg),
        .height     (height_reg),
        .snake_mode (snake_reg),
        .col        (s_tdata[5:0]),
        .row        (s_tdata[11:6]),
        .geom       (geom)
    );

    lmfb_store #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_accept = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd16;
            height_reg <= 7'd8;
            snake_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_SNAKE:  snake_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (func == FUNC_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (func == FUNC_READ || func == FUNC_EMIT)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready   = 1'b0;
        clr_active = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_CLEAR: clr_active = 1'b1;
            ST_IDLE:  s_tready   = 1'b1;
            ST_FETCH: load_out   = !out_valid_reg || m_tready;
            default:  ;
        endcase
    end

    // Hold state and sweep counter; reset starts a clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_active)
            begin
                clr_cnt_reg <= (clr_cnt_reg == CLR_LAST) ? '0 : clr_cnt_reg + AW'(1);
            end
        end
    end

    // Drive the store: sweep zeros, pixel writes, reads for readback and frame bytes
    always_comb
    begin
        wr_en   = clr_active || (s_accept && func == FUNC_WRITE && geom.pos_ok);
        wr_addr = clr_active ? clr_cnt_reg : AW'(geom.pos);
        wr_data = clr_active ? 24'd0 : {s_tdata[19:12], s_tdata[27:20], s_tdata[35:28]};
        rd_en   = s_accept && (func == FUNC_READ || func == FUNC_EMIT);
        rd_addr = (func == FUNC_READ) ? AW'(geom.pos) : AW'(pix_idx_reg);
    end

    // Keep the command context for the fetch cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_emit_reg <= 1'b0;
            pos_ok_reg  <= 1'b0;
        end
        else if (rd_en)
        begin
            is_emit_reg <= (func == FUNC_EMIT);
            pos_ok_reg  <= geom.pos_ok;
        end
    end

    // Pick the pixel byte of the current phase
    always_comb
    begin
        case (phase_reg)
            PHASE_RED:   pix_byte = rd_data[23:16];
            PHASE_GREEN: pix_byte = rd_data[15:8];
            PHASE_BLUE:  pix_byte = rd_data[7:0];
            default:     pix_byte = 8'd0;
        endcase
    end

    // Build the result item and advance the frame sequencer
    always_comb
    begin
        cursor_next      = cursor_reg;
        pix_idx_next     = pix_idx_reg;
        phase_next       = phase_reg;
        sum_next         = sum_reg;
        kind_next        = KIND_PIXEL;
        red_out_next     = 8'd0;
        green_out_next   = 8'd0;
        blue_out_next    = 8'd0;
        frame_byte_next  = 8'd0;
        frame_end_next   = 1'b0;
        coord_error_next = 1'b0;
        if (!is_emit_reg)
        begin
            coord_error_next = !pos_ok_reg;
            if (pos_ok_reg)
            begin
                red_out_next   = rd_data[23:16];
                green_out_next = rd_data[15:8];
                blue_out_next  = rd_data[7:0];
            end
        end
        else
        begin
            kind_next = KIND_FRAME;
            if (cursor_reg == '0)
            begin
                frame_byte_next = HEADER_BYTE;
                sum_next        = sum_reg + SUM_W'(HEADER_BYTE);
                cursor_next     = CW'(1);
                pix_idx_next    = '0;
                phase_next      = PHASE_RED;
            end
            else if (cursor_reg == geom.nbytes + CW'(1) || cursor_reg <= geom.nbytes)
            begin
                if (cursor_reg <= geom.nbytes)
                begin
                    frame_byte_next = pix_byte;
                    sum_next        = sum_reg + SUM_W'(pix_byte);
                end
                else
                begin
                    frame_byte_next = sum_reg[15:8];
                end
                // step the byte position along with the cursor
                cursor_next = cursor_reg + CW'(1);
                if (phase_reg == PHASE_BLUE)
                begin
                    phase_next   = PHASE_RED;
                    pix_idx_next = pix_idx_reg + PCW'(1);
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 2'd1);
                end
            end
            else
            begin
                frame_byte_next = sum_reg[7:0];
                frame_end_next  = 1'b1;
                cursor_next     = '0;
                sum_next        = '0;
                pix_idx_next    = '0;
                phase_next      = PHASE_RED;
            end
        end
    end

    // Register the sequencer on each frame byte loaded into the output item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            pix_idx_reg <= '0;
            phase_reg   <= PHASE_RED;
            sum_reg     <= '0;
        end
        else if (load_out && is_emit_reg)
        begin
            cursor_reg  <= cursor_next;
            pix_idx_reg <= pix_idx_next;
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
        end
    end

    // Output item valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output item payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg        <= kind_next;
            red_out_reg     <= red_out_next;
            green_out_reg   <= green_out_next;
            blue_out_reg    <= blue_out_next;
            frame_byte_reg  <= frame_byte_next;
            frame_end_reg   <= frame_end_next;
            coord_error_reg <= coord_error_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {frame_byte_reg, blue_out_reg, green_out_reg, red_out_reg};
    assign m_tuser  = {coord_error_reg, kind_reg};
    assign m_tlast  = frame_end_reg;

    // The byte phase never leaves red, green, blue
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PHASE_BAD)
        else $error("frame byte phase out of range");

    // A rejected readback carries no colour
    a_err_no_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[23:0] == 24'd0 && m_tuser[0] == KIND_PIXEL))
        else $error("coordinate error item with colour");

    // Frame bytes carry no colour and no error; only they end a frame
    a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser[0] == KIND_FRAME && m_tdata[23:0] == 24'd0))
        else $error("frame end on a non-frame item");

    // No store read is issued during a clearing sweep
    a_no_read_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active |-> !rd_en && !load_out)
        else $error("store read during clear");

endmodule
